### sv/u2r_pkg.sv
// Shared types and constants for the UTF-8 to RTF escape core
`timescale 1ns / 1ps

package u2r_pkg;

	// Width of the gathered code point and of its decimal form
	localparam int ACC_W      = 31;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int CNT_W      = 5;

	// Upper bounds of the lead byte classes
	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MAX = 8'hF7;
	localparam logic [7:0] LEAD5_MAX = 8'hFB;
	localparam logic [7:0] LEAD6_MAX = 8'hFD;

	// Code emitted for the two bytes that can never start a sequence
	localparam logic [ACC_W-1:0] CODE_SUBST = 31'd63;

	// ASCII characters used by the escapes
	localparam logic [6:0] CH_BSLASH = 7'h5C;
	localparam logic [6:0] CH_LBRACE = 7'h7B;
	localparam logic [6:0] CH_RBRACE = 7'h7D;
	localparam logic [6:0] CH_LF     = 7'h0A;
	localparam logic [6:0] CH_U      = 7'h75;
	localparam logic [6:0] CH_P      = 7'h70;
	localparam logic [6:0] CH_A      = 7'h61;
	localparam logic [6:0] CH_R      = 7'h72;
	localparam logic [6:0] CH_SPACE  = 7'h20;
	localparam logic [6:0] CH_QMARK  = 7'h3F;
	localparam logic [6:0] CH_ZERO   = 7'h30;

	// Kind of output run a word calls for
	typedef enum logic [1:0] {
		K_CHAR,
		K_ESC2,
		K_PAR,
		K_UNI
	} cmd_kind_t;

	// One queued command from the front to the back
	typedef struct packed {
		cmd_kind_t        kind;
		logic [6:0]       ch;
		logic [ACC_W-1:0] value;
		logic             last;
	} cmd_t;

	// Back end sequencer states
	typedef enum logic [1:0] {
		B_IDLE,
		B_CONV,
		B_EMIT
	} back_state_t;

endpackage

### sv/u2r_front.sv
// Front end: accepts input words, tracks UTF-8 sequences and queues output commands
`timescale 1ns / 1ps

module u2r_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    in_byte,
	input  logic          end_of_text,
	input  logic          q_full,
	output logic          q_push,
	output u2r_pkg::cmd_t q_cmd
);

	logic [2:0]                 pend_q, pend_nx;
	logic [u2r_pkg::ACC_W-1:0]  acc_q, acc_nx, acc_tail;
	logic                       emit_cmd;
	logic                       accept;

	// Classify the word and work out the next sequence state
	always_comb begin
		pend_nx    = pend_q;
		acc_nx     = acc_q;
		acc_tail   = acc_q;
		emit_cmd   = 1'b0;
		q_cmd.kind  = u2r_pkg::K_CHAR;
		q_cmd.ch    = in_byte[6:0];
		q_cmd.value = '0;
		q_cmd.last  = end_of_text;

		if (pend_q != 3'd0) begin
			// continuation: any byte, low six bits shifted in
			acc_nx  = {acc_q[24:0], in_byte[5:0]};
			pend_nx = pend_q - 3'd1;
			if (pend_nx == 3'd0) begin
				emit_cmd    = 1'b1;
				q_cmd.kind  = u2r_pkg::K_UNI;
				q_cmd.value = acc_nx;
			end
		end else if (in_byte <= u2r_pkg::ASCII_MAX) begin
			emit_cmd = 1'b1;
			if (in_byte[6:0] == u2r_pkg::CH_LBRACE || in_byte[6:0] == u2r_pkg::CH_RBRACE ||
				in_byte[6:0] == u2r_pkg::CH_BSLASH) begin
				q_cmd.kind = u2r_pkg::K_ESC2;
			end else if (in_byte[6:0] == u2r_pkg::CH_LF) begin
				q_cmd.kind = u2r_pkg::K_PAR;
			end
		end else if (in_byte <= u2r_pkg::LEAD2_MAX) begin
			acc_nx  = {26'd0, in_byte[4:0]};
			pend_nx = 3'd1;
		end else if (in_byte <= u2r_pkg::LEAD3_MAX) begin
			acc_nx  = {27'd0, in_byte[3:0]};
			pend_nx = 3'd2;
		end else if (in_byte <= u2r_pkg::LEAD4_MAX) begin
			acc_nx  = {28'd0, in_byte[2:0]};
			pend_nx = 3'd3;
		end else if (in_byte <= u2r_pkg::LEAD5_MAX) begin
			acc_nx  = {29'd0, in_byte[1:0]};
			pend_nx = 3'd4;
		end else if (in_byte <= u2r_pkg::LEAD6_MAX) begin
			acc_nx  = {30'd0, in_byte[0]};
			pend_nx = 3'd5;
		end else begin
			emit_cmd    = 1'b1;
			q_cmd.kind  = u2r_pkg::K_UNI;
			q_cmd.value = u2r_pkg::CODE_SUBST;
		end

		// missing bytes of a cut-short sequence count as zero
		case (pend_nx)
			3'd1:    acc_tail = {acc_nx[24:0], 6'd0};
			3'd2:    acc_tail = {acc_nx[18:0], 12'd0};
			3'd3:    acc_tail = {acc_nx[12:0], 18'd0};
			3'd4:    acc_tail = {acc_nx[6:0], 24'd0};
			3'd5:    acc_tail = {acc_nx[0], 30'd0};
			default: acc_tail = acc_nx;
		endcase

		if (end_of_text) begin
			if (pend_nx != 3'd0) begin
				emit_cmd    = 1'b1;
				q_cmd.kind  = u2r_pkg::K_UNI;
				q_cmd.value = acc_tail;
			end
			pend_nx = 3'd0;
			acc_nx  = '0;
		end
	end

	assign in_stall = q_full;
	assign accept   = in_valid & ~q_full;
	assign q_push   = accept & emit_cmd;

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
			acc_q  <= '0;
		end else if (accept) begin
			pend_q <= pend_nx;
			acc_q  <= acc_nx;
		end
	end

endmodule

### sv/u2r_fifo.sv
// Short command queue between front and back ends
`timescale 1ns / 1ps

module u2r_fifo #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  u2r_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          pop,
	output u2r_pkg::cmd_t rd_cmd,
	output logic          empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	u2r_pkg::cmd_t    mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_cmd = mem[rd_ptr_q];

endmodule

### sv/u2r_back.sv
// Back end: decimal conversion and character sequencing into the output register
`timescale 1ns / 1ps

module u2r_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  u2r_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [6:0]    out_char,
	output logic          run_last,
	output logic          text_done
);

	u2r_pkg::back_state_t       state_q, state_nx;
	u2r_pkg::cmd_kind_t         kind_q;
	logic [6:0]                 ch_q;
	logic                       last_q;
	logic [u2r_pkg::ACC_W-1:0]  bin_q;
	logic [u2r_pkg::BCD_W-1:0]  bcd_q, bcd_adj;
	logic [u2r_pkg::CNT_W-1:0]  cnt_q;
	logic [3:0]                 idx_q;
	logic                       out_valid_q;
	logic [6:0]                 out_char_q;
	logic                       run_last_q, text_done_q;

	logic       conv_step, emit_fire, out_free, final_char;
	logic [3:0] ndig, char_len, dig_sel;
	logic [3:0] digit;
	logic [6:0] char_nx;

	// Add-three correction on each decimal digit before the shift
	always_comb begin
		for (int k = 0; k < u2r_pkg::BCD_DIGITS; k++) begin
			bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
			                                               : bcd_q[4*k +: 4];
		end
	end

	// Significant digits, at least one
	always_comb begin
		ndig = 4'd1;
		for (int k = 1; k < u2r_pkg::BCD_DIGITS; k++) begin
			if (bcd_q[4*k +: 4] != 4'd0) begin
				ndig = 4'(k + 1);
			end
		end
	end

	// Digit for the current position, most significant first
	assign dig_sel = ndig + 4'd1 - idx_q;
	always_comb begin
		digit = 4'd0;
		for (int k = 0; k < u2r_pkg::BCD_DIGITS; k++) begin
			if (dig_sel == 4'(k)) begin
				digit = bcd_q[4*k +: 4];
			end
		end
	end

	// Run length and the character at the current position
	always_comb begin
		char_len = 4'd1;
		char_nx  = ch_q;
		case (kind_q)
			u2r_pkg::K_CHAR: begin
				char_len = 4'd1;
				char_nx  = ch_q;
			end
			u2r_pkg::K_ESC2: begin
				char_len = 4'd2;
				char_nx  = (idx_q == 4'd0) ? u2r_pkg::CH_BSLASH : ch_q;
			end
			u2r_pkg::K_PAR: begin
				char_len = 4'd5;
				case (idx_q)
					4'd0:    char_nx = u2r_pkg::CH_BSLASH;
					4'd1:    char_nx = u2r_pkg::CH_P;
					4'd2:    char_nx = u2r_pkg::CH_A;
					4'd3:    char_nx = u2r_pkg::CH_R;
					default: char_nx = u2r_pkg::CH_SPACE;
				endcase
			end
			u2r_pkg::K_UNI: begin
				char_len = ndig + 4'd3;
				if (idx_q == 4'd0) begin
					char_nx = u2r_pkg::CH_BSLASH;
				end else if (idx_q == 4'd1) begin
					char_nx = u2r_pkg::CH_U;
				end else if (idx_q == ndig + 4'd2) begin
					char_nx = u2r_pkg::CH_QMARK;
				end else begin
					char_nx = u2r_pkg::CH_ZERO + {3'd0, digit};
				end
			end
			default: begin
				char_len = 4'd1;
				char_nx  = ch_q;
			end
		endcase
	end

	assign final_char = (idx_q == char_len - 4'd1);
	assign out_free   = ~out_valid_q | ~out_stall;

	// Sequencer next state and controls
	always_comb begin
		state_nx  = state_q;
		q_pop     = 1'b0;
		conv_step = 1'b0;
		emit_fire = 1'b0;
		case (state_q)
			u2r_pkg::B_IDLE: begin
				if (!q_empty) begin
					q_pop    = 1'b1;
					state_nx = (q_cmd.kind == u2r_pkg::K_UNI) ? u2r_pkg::B_CONV
					                                          : u2r_pkg::B_EMIT;
				end
			end
			u2r_pkg::B_CONV: begin
				conv_step = 1'b1;
				if (cnt_q == u2r_pkg::CNT_W'(u2r_pkg::ACC_W - 1)) begin
					state_nx = u2r_pkg::B_EMIT;
				end
			end
			u2r_pkg::B_EMIT: begin
				if (out_free) begin
					emit_fire = 1'b1;
					if (final_char) begin
						state_nx = u2r_pkg::B_IDLE;
					end
				end
			end
			default: state_nx = u2r_pkg::B_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= u2r_pkg::B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			out_valid_q <= emit_fire | (out_valid_q & out_stall);
		end
	end

	// Command, conversion and output payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q <= q_cmd.kind;
			ch_q   <= q_cmd.ch;
			last_q <= q_cmd.last;
			bin_q  <= q_cmd.value;
			bcd_q  <= '0;
			cnt_q  <= '0;
			idx_q  <= 4'd0;
		end
		if (conv_step) begin
			bcd_q <= {bcd_adj[u2r_pkg::BCD_W-2:0], bin_q[u2r_pkg::ACC_W-1]};
			bin_q <= {bin_q[u2r_pkg::ACC_W-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
		end
		if (emit_fire) begin
			idx_q       <= idx_q + 4'd1;
			out_char_q  <= char_nx;
			run_last_q  <= final_char;
			text_done_q <= final_char & last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign run_last  = run_last_q;
	assign text_done = text_done_q;

endmodule

### sv/utf8_to_rtf_escape_core.sv
// Top level of the UTF-8 to RTF escape core
// A plain character passes the queue, the back end command registers and the output register.
// The back end emits each queued word's characters in turn, holding while out_stall is high;
// a word with no output is not queued; a \u escape first runs shift-add-three conversion.
// The command queue lets the front take new words while the back end is still emitting.
// Reset (arst_n low, asynchronous) clears the sequence state, the queue and the output valid.
`timescale 1ns / 1ps

module utf8_to_rtf_escape_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] out_char,
	output logic       run_last,
	output logic       text_done
);

	logic          q_push, q_full, q_pop, q_empty;
	u2r_pkg::cmd_t q_wr_cmd, q_rd_cmd;

	// Input side: sequence tracking and classification
	u2r_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_wr_cmd)
	);

	// Decoupling queue
	u2r_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (q_wr_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.rd_cmd (q_rd_cmd),
		.empty  (q_empty)
	);

	// Output side: conversion and character emission
	u2r_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (q_rd_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.run_last  (run_last),
		.text_done (text_done)
	);

	// Queue never written when full nor read when empty
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue read while empty");

	// End of text only ever closes a run
	a_done_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && text_done) |-> run_last)
		else $error("text_done without run_last");

endmodule

### test/utf8_to_rtf_escape_core_tb.sv
// Self-checking testbench for the UTF-8 to RTF escape core with a predicting scoreboard
`timescale 1ns / 1ps

module utf8_to_rtf_escape_core_tb;

	localparam int RANDOM_WORDS     = 500;
	localparam int DIRECTED_WORDS   = 25;
	localparam int DRAIN_CYCLES     = 120;
	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int LONG_HOLD_AT     = 80;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int PAUSE_AT         = 300;

	// Directed words: bit 8 is the end of text flag
	localparam logic [8:0] DIRECTED [DIRECTED_WORDS] = '{
		9'h000, 9'h07F, 9'h07B, 9'h07D, 9'h05C, 9'h00A,	// extremes and escaped ASCII
		9'h0C3, 9'h0A9,					// two-byte sequence
		9'h0E2, 9'h082, 9'h0AC,				// three-byte sequence
		9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,	// six bytes, largest code point
		9'h080, 9'h041,					// stray continuation, ASCII taken as continuation
		9'h0FE, 9'h0FF,					// bytes that never lead
		9'h0E5, 9'h1C0,					// lead byte as continuation, cut short by end
		9'h1F9,						// five-byte lead ended at once
		9'h141						// end of text on a plain character
	};

	// One expected output word
	typedef struct {
		logic [6:0] ch;
		logic       run_end;
		logic       text_end;
	} rtf_char_t;

	// Predicts the escaped character stream and checks the output against it
	class rtf_escape_scoreboard;
		rtf_char_t                 expected_chars[$];
		rtf_char_t                 burst[$];
		logic [2:0]                cont_left;
		logic [u2r_pkg::ACC_W-1:0] code_acc;
		int                        mismatches;

		function new();
			cont_left  = '0;
			code_acc   = '0;
			mismatches = 0;
		endfunction

		function void add_char(logic [6:0] ch);
			rtf_char_t c;
			c.ch       = ch;
			c.run_end  = 1'b0;
			c.text_end = 1'b0;
			burst.push_back(c);
		endfunction

		// \u, decimal code point, question mark
		function void add_unicode(logic [u2r_pkg::ACC_W-1:0] code);
			int unsigned val;
			int unsigned digits[$];
			val = {1'b0, code};
			add_char(u2r_pkg::CH_BSLASH);
			add_char(u2r_pkg::CH_U);
			do begin
				digits.push_front(val % 10);
				val = val / 10;
			end while (val != 0);
			foreach (digits[i])
				add_char(u2r_pkg::CH_ZERO + 7'(digits[i]));
			add_char(u2r_pkg::CH_QMARK);
		endfunction

		// Called for every accepted input word
		function void note_byte(logic [7:0] b, logic eot);
			burst.delete();
			if (cont_left != 0) begin
				code_acc  = {code_acc[u2r_pkg::ACC_W-7:0], b[5:0]};
				cont_left = cont_left - 3'd1;
				if (cont_left == 0)
					add_unicode(code_acc);
			end else if (b <= u2r_pkg::ASCII_MAX) begin
				if (b[6:0] == u2r_pkg::CH_LBRACE || b[6:0] == u2r_pkg::CH_RBRACE ||
					b[6:0] == u2r_pkg::CH_BSLASH) begin
					add_char(u2r_pkg::CH_BSLASH);
					add_char(b[6:0]);
				end else if (b[6:0] == u2r_pkg::CH_LF) begin
					add_char(u2r_pkg::CH_BSLASH);
					add_char(u2r_pkg::CH_P);
					add_char(u2r_pkg::CH_A);
					add_char(u2r_pkg::CH_R);
					add_char(u2r_pkg::CH_SPACE);
				end else begin
					add_char(b[6:0]);
				end
			end else if (b <= u2r_pkg::LEAD2_MAX) begin
				code_acc  = u2r_pkg::ACC_W'(b[4:0]);
				cont_left = 3'd1;
			end else if (b <= u2r_pkg::LEAD3_MAX) begin
				code_acc  = u2r_pkg::ACC_W'(b[3:0]);
				cont_left = 3'd2;
			end else if (b <= u2r_pkg::LEAD4_MAX) begin
				code_acc  = u2r_pkg::ACC_W'(b[2:0]);
				cont_left = 3'd3;
			end else if (b <= u2r_pkg::LEAD5_MAX) begin
				code_acc  = u2r_pkg::ACC_W'(b[1:0]);
				cont_left = 3'd4;
			end else if (b <= u2r_pkg::LEAD6_MAX) begin
				code_acc  = u2r_pkg::ACC_W'(b[0]);
				cont_left = 3'd5;
			end else begin
				add_unicode(u2r_pkg::CODE_SUBST);
			end

			// End of text: missing continuation bytes count as zero
			if (eot) begin
				if (cont_left != 0) begin
					while (cont_left != 0) begin
						code_acc  = {code_acc[u2r_pkg::ACC_W-7:0], 6'd0};
						cont_left = cont_left - 3'd1;
					end
					add_unicode(code_acc);
				end
				cont_left = '0;
				code_acc  = '0;
			end

			if (burst.size() > 0) begin
				burst[burst.size()-1].run_end  = 1'b1;
				burst[burst.size()-1].text_end = eot;
			end
			foreach (burst[i])
				expected_chars.push_back(burst[i]);
		endfunction

		// Called for every accepted output word
		function void check_char(logic [6:0] ch, logic run_end, logic text_end);
			rtf_char_t want;
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected char %h run_last %b text_done %b", $time,
					ch, run_end, text_end);
				mismatches++;
				return;
			end
			want = expected_chars.pop_front();
			if (want.ch !== ch || want.run_end !== run_end || want.text_end !== text_end) begin
				$display("%0t: char exp %h got %h, run_last exp %b got %b, %s %b got %b",
					$time, want.ch, ch, want.run_end, run_end, "text_done exp",
					want.text_end, text_end);
				mismatches++;
			end
		endfunction

		function bit all_done();
			return expected_chars.size() == 0;
		endfunction
	endclass

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte     = 8'h00;
	logic       end_of_text = 1'b0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic [6:0] out_char;
	logic       run_last;
	logic       text_done;

	rtf_escape_scoreboard sb;
	int bytes_sent   = 0;
	int chars_taken  = 0;
	int quiet_cycles = 0;
	bit tx_quiet     = 1'b0;
	bit rx_quiet     = 1'b0;

	utf8_to_rtf_escape_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.run_last    (run_last),
		.text_done   (text_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one input word after a random gap and wait for it to be taken
	task automatic send_byte(input logic [7:0] b, input logic eot);
		int gap;
		if (bytes_sent % 40 == 0)
			tx_quiet = ($urandom_range(0, 3) == 0);
		gap = tx_quiet ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		in_byte     <= b;
		end_of_text <= eot;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_byte(b, eot);
		bytes_sent++;
	endtask

	function automatic logic rare_end();
		return $urandom_range(0, 19) == 0;
	endfunction

	// Random text: mostly well-formed sequences, some broken ones and noise
	task automatic send_random_text();
		int         pick;
		int         len;
		int         cut;
		logic [7:0] lead;
		while (bytes_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
			if (bytes_sent >= PAUSE_AT && bytes_sent < PAUSE_AT + 10) begin
				// let the core drain completely once
				in_valid <= 1'b0;
				@(posedge clk);
				while (!sb.all_done())
					@(posedge clk);
				bytes_sent = PAUSE_AT + 10;
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				case ($urandom_range(0, 5))
					0: lead = 8'(u2r_pkg::CH_LBRACE);
					1: lead = 8'(u2r_pkg::CH_RBRACE);
					2: lead = 8'(u2r_pkg::CH_BSLASH);
					3: lead = 8'(u2r_pkg::CH_LF);
					default: lead = 8'($urandom_range(0, 127));
				endcase
				send_byte(lead, rare_end());
			end else if (pick < 88) begin
				len = $urandom_range(2, 6);
				case (len)
					2: lead = 8'($urandom_range(8'hC0, 8'hDF));
					3: lead = 8'($urandom_range(8'hE0, 8'hEF));
					4: lead = 8'($urandom_range(8'hF0, 8'hF7));
					5: lead = 8'($urandom_range(8'hF8, 8'hFB));
					default: lead = 8'($urandom_range(8'hFC, 8'hFD));
				endcase
				cut = (pick >= 76) ? $urandom_range(1, len - 1) : len;
				for (int i = 0; i < cut; i++) begin
					if (i == 0)
						send_byte(lead, cut < len && cut == 1 && pick < 82);
					else if (i == cut - 1 && cut < len && pick < 82)
						send_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b1);
					else
						send_byte(8'h80 | 8'($urandom_range(0, 63)),
							i == len - 1 && rare_end());
				end
				// broken without end flag: any byte lands as a continuation
				if (cut < len && pick >= 82)
					send_byte(8'($urandom_range(0, 255)), 1'b0);
			end else begin
				send_byte(8'($urandom_range(0, 255)), rare_end());
			end
		end
	endtask

	// Main sequence: reset, directed words, random text, drain
	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i])
			send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
		send_random_text();
		send_byte(8'h2E, 1'b1);
		in_valid <= 1'b0;
		while (!sb.all_done())
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.all_done())
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Output side: random stalls, one long hold to back the core up
	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (chars_taken % 40 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
			gap = rx_quiet ? 0 : $urandom_range(0, 8);
			if (chars_taken == LONG_HOLD_AT)
				gap = LONG_HOLD_CYCLES;
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			sb.check_char(out_char, run_last, text_done);
			chars_taken++;
		end
	end

	// Watchdog: too long without any word moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
